/* rtl/timestamp_extend_and_convert_top_assert.svh */
// Assertion macros for the timestamp extension and conversion block.
`ifndef TIMESTAMP_EXTEND_AND_CONVERT_TOP_ASSERT_SVH
`define TIMESTAMP_EXTEND_AND_CONVERT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSX_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timestamp block check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timestamp block check failed");

`endif

/* rtl/tsx_pkg.sv */
// Package with the types and constants of the timestamp extension and conversion block.
`timescale 1ns / 1ps

package tsx_pkg;

	// Configuration port.
	localparam int CfgIndexW = 8;
	localparam int CfgDataW  = 32;
	localparam logic [CfgIndexW-1:0] REG_TICK_RATE = 8'd0;
	localparam logic [CfgIndexW-1:0] REG_FULL_MODE = 8'd1;

	// Arithmetic constants.
	localparam logic [31:0] LowQuarterEnd    = 32'h4000_0000;
	localparam logic [31:0] HalfPoint        = 32'h8000_0000;
	localparam logic [31:0] ErrWindow        = 32'h0100_0000;
	localparam logic [30:0] NearBoundary     = 31'h7F00_0000;
	localparam logic [30:0] CoarseOffset     = 31'h4000_0000;
	localparam logic [29:0] NsPerSec         = 30'd1000000000;

	// Shared divider geometry.
	localparam int DivW     = 64;
	localparam int DivisorW = 32;
	localparam int StepW    = $clog2(DivW);

	typedef enum logic {
		CMD_TICK    = 1'b0,
		CMD_CONVERT = 1'b1
	} tsx_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_SEC,
		ST_SCALE,
		ST_DIV_NS,
		ST_DONE
	} tsx_state_t;

	// Result of the extension stage for one transaction.
	typedef struct packed {
		logic [63:0] ticks;
		logic [32:0] count_next;
		logic        err;
	} tsx_ext_t;

	// Status of the shared divider.
	typedef struct packed {
		logic busy;
		logic done;
	} tsx_div_stat_t;

endpackage

/* rtl/tsx_chan_ifs.sv */
// Handshake interfaces for the item and result channels.
`timescale 1ns / 1ps

interface tsx_item_if;
	import tsx_pkg::*;

	logic        valid;
	logic        ready;
	tsx_cmd_t    command;
	logic [31:0] capture_low;
	logic [31:0] reading_high_first;
	logic [31:0] reading_low;
	logic [31:0] reading_high_second;

	modport source (
		output valid, command, capture_low, reading_high_first, reading_low,
			reading_high_second,
		input  ready
	);
	modport sink (
		input  valid, command, capture_low, reading_high_first, reading_low,
			reading_high_second,
		output ready
	);
endinterface

interface tsx_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] extended_ticks;
	logic [63:0] whole_seconds;
	logic [29:0] nanoseconds;
	logic [63:0] coarse_time;
	logic        rollover_error;

	modport source (
		output valid, extended_ticks, whole_seconds, nanoseconds, coarse_time,
			rollover_error,
		input  ready
	);
	modport sink (
		input  valid, extended_ticks, whole_seconds, nanoseconds, coarse_time,
			rollover_error,
		output ready
	);
endinterface

/* rtl/tsx_extend.sv */
// Extension of a 32-bit capture to 64 bits of ticks and update of the half-rollover count.
`timescale 1ns / 1ps

module tsx_extend (
	input  logic             full_mode,
	input  logic [32:0]      count,
	input  tsx_pkg::tsx_cmd_t command,
	input  logic [31:0]      capture_low,
	input  logic [31:0]      reading_high_first,
	input  logic [31:0]      reading_low,
	input  logic [31:0]      reading_high_second,
	output tsx_pkg::tsx_ext_t ext
);
	import tsx_pkg::*;

	logic        cap_low_q1;
	logic        cap_high_q4;
	logic [31:0] now_hi;
	logic [63:0] now;
	logic [31:0] ext_hi;
	logic [31:0] cnt_upper;
	logic [31:0] err_ref;
	logic [31:0] err_dist;

	// Capture in the first or last quarter of the 32-bit period.
	assign cap_low_q1  = (capture_low < LowQuarterEnd);
	assign cap_high_q4 = (capture_low[31:30] == 2'b11);

	// A torn reading: low half of the period pairs with the second upper read.
	assign now_hi = ((reading_high_first == reading_high_second) || reading_low[31])
		? reading_high_first : reading_high_second;
	assign now = {now_hi, reading_low};

	// Upper word of a capture against the full reading.
	always_comb begin
		ext_hi = now[63:32];
		if (cap_low_q1 && now[31]) begin
			ext_hi = now[63:32] + 32'd1;
		end else if (cap_high_q4 && !now[31]) begin
			ext_hi = now[63:32] - 32'd1;
		end
	end

	// Upper word of a capture against the half-rollover count.
	always_comb begin
		cnt_upper = count[32:1];
		if (cap_low_q1 && count[0]) begin
			cnt_upper = count[32:1] + 32'd1;
		end else if (cap_high_q4 && !count[0]) begin
			cnt_upper = count[32:1] - 32'd1;
		end
	end

	// Distance of a counter-mode tick from the point where it should fire.
	assign err_ref  = count[0] ? 32'd0 : HalfPoint;
	assign err_dist = capture_low - err_ref;

	// Select the tick count, the next count and the error flag.
	always_comb begin
		ext.ticks      = {cnt_upper, capture_low};
		ext.count_next = count;
		ext.err        = 1'b0;
		if (full_mode) begin
			if (command == CMD_CONVERT) begin
				ext.ticks = {ext_hi, capture_low};
			end else begin
				ext.ticks = now;
				if (now[30:0] > NearBoundary) begin
					ext.count_next = now[63:31] + 33'd1;
				end else begin
					ext.count_next = now[63:31];
				end
			end
		end else if (command == CMD_TICK) begin
			ext.err        = (err_dist > ErrWindow) && (err_dist < (32'd0 - ErrWindow));
			ext.count_next = count + 33'd1;
		end
	end

endmodule

/* rtl/tsx_div.sv */
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module tsx_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tsx_pkg::DivW-1:0]      dividend,
	input  logic [tsx_pkg::DivisorW-1:0]  divisor,
	output tsx_pkg::tsx_div_stat_t        stat,
	output logic [tsx_pkg::DivW-1:0]      quotient,
	output logic [tsx_pkg::DivisorW-1:0]  remainder
);
	import tsx_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [StepW-1:0]    step_q;
	logic [DivW-1:0]     quo_q;
	logic [DivisorW-1:0] rem_q;
	logic [DivisorW-1:0] div_q;
	logic [DivisorW:0]   trial;
	logic [DivisorW:0]   diff;
	logic                fits;

	// One compare and subtract per step.
	assign trial = {rem_q, quo_q[DivW-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = (trial >= {1'b0, div_q});

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + StepW'(1);
				if (step_q == StepW'(DivW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend bits shift out as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DivW-2:0], fits};
			rem_q <= fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* rtl/timestamp_extend_and_convert_top.sv */
// Top level: extends 32-bit tick captures to 64 bits and converts them to seconds and nanoseconds.
//
// Each transaction on the item channel gives one result. The work is done by one shared
// 64-step restoring divider, used once for whole seconds and once for the nanoseconds
// (remainder times 10^9 over the tick rate), one quotient bit per cycle, plus the
// sequencing states and the scaling multiply. The block takes one item at a time; a
// finished result waits in an output register, so the next item may be accepted while
// it is unclaimed. If the output register is still full when the next result is
// finished, the sequencer holds that result and the input stays stalled until the
// register is claimed. A tick rate of zero divides as one. The half-rollover count is
// updated when the item is accepted and coarse_time reflects the updated count.
// Configuration writes are meant for idle periods only.
`timescale 1ns / 1ps

module timestamp_extend_and_convert_top (
	input  logic                           clk,
	input  logic                           arst_n,
	tsx_item_if.sink                       item,
	tsx_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [tsx_pkg::CfgIndexW-1:0]  cfg_index,
	input  logic [tsx_pkg::CfgDataW-1:0]   cfg_wdata
);
	import tsx_pkg::*;
	`include "timestamp_extend_and_convert_top_assert.svh"

	tsx_state_t    state_q, state_d;
	logic [31:0]   tick_rate_q;
	logic          full_mode_q;
	logic [32:0]   count_q;
	tsx_ext_t      ext;
	logic          item_acc;
	logic          div_start;
	logic [63:0]   div_dividend;
	logic [31:0]   divisor;
	tsx_div_stat_t div_stat;
	logic [63:0]   div_quo;
	logic [31:0]   div_rem;
	logic [63:0]   ticks_q;
	logic [63:0]   coarse_q;
	logic          err_q;
	logic [63:0]   sec_q;
	logic [61:0]   prod_q;
	logic [29:0]   ns_q;
	logic          out_free;
	logic          out_load;
	logic          out_valid_q;
	logic [63:0]   out_ticks_q;
	logic [63:0]   out_sec_q;
	logic [29:0]   out_ns_q;
	logic [63:0]   out_coarse_q;
	logic          out_err_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= 32'd1;
			full_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TICK_RATE: tick_rate_q <= cfg_wdata;
				REG_FULL_MODE: full_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign divisor = (tick_rate_q == 32'd0) ? 32'd1 : tick_rate_q;

	// Extension of the incoming capture.
	tsx_extend u_extend (
		.full_mode           (full_mode_q),
		.count               (count_q),
		.command             (item.command),
		.capture_low         (item.capture_low),
		.reading_high_first  (item.reading_high_first),
		.reading_low         (item.reading_low),
		.reading_high_second (item.reading_high_second),
		.ext                 (ext)
	);

	// Shared divider.
	tsx_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (divisor),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign item.ready = (state_q == ST_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and divider control.
	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = ext.ticks;
		out_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					div_start = 1'b1;
					state_d   = ST_DIV_SEC;
				end
			end
			ST_DIV_SEC: begin
				if (div_stat.done) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				div_start    = 1'b1;
				div_dividend = {2'b00, prod_q};
				state_d      = ST_DIV_NS;
			end
			ST_DIV_NS: begin
				if (div_stat.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Half-rollover count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (item_acc) begin
			count_q <= ext.count_next;
		end
	end

	// Working registers of the transaction in flight.
	always_ff @(posedge clk) begin
		if (item_acc) begin
			ticks_q  <= ext.ticks;
			coarse_q <= {ext.count_next, CoarseOffset};
			err_q    <= ext.err;
		end
		if (state_q == ST_DIV_SEC && div_stat.done) begin
			sec_q  <= div_quo;
			prod_q <= {30'd0, div_rem} * {32'd0, NsPerSec};
		end
		if (state_q == ST_DIV_NS && div_stat.done) begin
			ns_q <= div_quo[29:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ticks_q  <= ticks_q;
			out_sec_q    <= sec_q;
			out_ns_q     <= ns_q;
			out_coarse_q <= coarse_q;
			out_err_q    <= err_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.extended_ticks = out_ticks_q;
	assign result.whole_seconds  = out_sec_q;
	assign result.nanoseconds    = out_ns_q;
	assign result.coarse_time    = out_coarse_q;
	assign result.rollover_error = out_err_q;

	// An accepted item starts the divider straight away.
	`TSX_ASSERT_NEXT(a_div_starts, item_acc, div_stat.busy)
	// The block never offers to take an item while the divider is working.
	`TSX_ASSERT_NOW(a_ready_idle_div, item.ready, !div_stat.busy)
	// A finished transaction always reaches the output register.
	`TSX_ASSERT_NEXT(a_result_loaded, state_q == ST_DONE && out_free, result.valid)
	// The count only moves when an item is taken.
	`TSX_ASSERT_NOW(a_count_on_accept, count_q != $past(count_q), $past(item_acc))

endmodule
